>>> src/tild_pkg.sv
package tild_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_FLAGS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_FLAGS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTR_CHAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIT_CHAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSP_CHAR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_CHAR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF_CHAR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EOL_CHAR    = 3'd7;

  localparam int IF_ISTRIP = 0;
  localparam int IF_ICRNL  = 1;
  localparam int IF_INLCR  = 2;

  localparam int LF_ISIG   = 0;
  localparam int LF_ICANON = 1;
  localparam int LF_ECHO   = 2;
  localparam int LF_ECHOE  = 3;
  localparam int LF_ECHONL = 4;

  localparam logic [7:0] ASCII_NUL   = 8'h00;
  localparam logic [7:0] ASCII_BS    = 8'h08;
  localparam logic [7:0] ASCII_NL    = 8'h0A;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_SP    = 8'h20;
  localparam logic [7:0] ASCII_AT    = 8'h40;
  localparam logic [7:0] ASCII_CARET = 8'h5E;
  localparam logic [7:0] ASCII_DEL   = 8'h7F;

  typedef struct packed {
    logic [2:0] input_flags;
    logic [4:0] local_flags;
    logic [7:0] intr_char;
    logic [7:0] quit_char;
    logic [7:0] susp_char;
    logic [7:0] erase_char;
    logic [7:0] eof_char;
    logic [7:0] eol_char;
  } tild_cfg_t;

  typedef enum logic [2:0] {
    CMP_INTR,
    CMP_QUIT,
    CMP_SUSP,
    CMP_ERASE,
    CMP_EOF,
    CMP_EOL
  } cmp_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIG,
    S_CLS,
    S_DEC,
    S_ERD,
    S_ECHO,
    S_FRD,
    S_FOUT
  } tild_state_t;

  typedef enum logic [1:0] {
    EK_SINGLE,
    EK_PAIR,
    EK_BS
  } echo_kind_t;

endpackage

>>> src/tild_if.sv
interface tild_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tild_out_if;
  logic       valid;
  logic       ready;
  logic       dest;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output dest, output out_byte, output last, input ready);
  modport sink (input valid, input dest, input out_byte, input last, output ready);
endinterface

>>> src/termios_input_line_discipline_core.sv
// Sequence: an accepted input passes S_SIG and S_CLS to S_DEC (and S_ERD for an erase), then
//   S_ECHO or S_FRD and S_FOUT; three signal compares and three class compares share one comparator.
// Throughput: one item at a time, next item after the last; echo results leave at one per cycle
//   unless stalled; flush bytes alternate S_FRD reads (one line buffer read port) and S_FOUT.
// Reset (synchronous, rst_n low): config to defaults, line count zero, output empty.
//   Line buffer contents are not cleared and are never read before written.
module termios_input_line_discipline_core
  import tild_pkg::*;
#(
  parameter int LINE_DEPTH = 32
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  tild_in_if.sink               in_ch,
  tild_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int RW = $clog2(LINE_DEPTH + 8);
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
  localparam logic [RW-1:0] MAX_RES = RW'(LINE_DEPTH + 1);

  function automatic logic is_ctrl(input logic [7:0] b);
    return (b < ASCII_SP) || (b == ASCII_DEL);
  endfunction

  function automatic logic [7:0] caret_letter(input logic [7:0] b);
    logic [7:0] s;
    s = ASCII_AT + b;
    return {1'b0, s[6:0]};
  endfunction

  tild_cfg_t   cfg_r;
  tild_state_t state_r, state_nxt;
  cmp_sel_t    sel_r, sel_nxt;
  logic [7:0]  in_byte_r;
  logic        sig_hit_r, sig_hit_nxt;
  logic        erase_hit_r, erase_hit_nxt;
  logic        eof_hit_r, eof_hit_nxt;
  logic        eol_hit_r, eol_hit_nxt;
  logic        rm_r, rm_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] f_len_r, f_len_nxt;
  logic [CW-1:0] f_idx_r, f_idx_nxt;
  echo_kind_t  e_kind_r, e_kind_nxt;
  logic [2:0]  e_len_r, e_len_nxt;
  logic [2:0]  e_idx_r, e_idx_nxt;
  logic [7:0]  e_byte_r, e_byte_nxt;
  logic        e_dest_r, e_dest_nxt;
  logic [RW-1:0] tot_r, tot_nxt;
  logic [RW-1:0] idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_dest_r, out_dest_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic [7:0]  line_mem [LINE_DEPTH];
  logic [7:0]  rd_data_r;

  logic [7:0]  stripped, mapped, cmp_a, echo_byte;
  logic        cmp_eq, echo_dest;
  logic        accept, slot_free, last_item, load;
  logic        line_end;
  logic [CW-1:0] count_dm1, count_p1;

  logic          dec_valid, dec_rd, dec_wr, dec_rm, dec_e_dest;
  echo_kind_t    dec_e_kind;
  logic [2:0]    dec_e_len;
  logic [7:0]    dec_e_byte;
  logic [CW-1:0] dec_f_len, dec_count;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] dec_sum, dec_tot;

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign last_item = (idx_r + RW'(1)) == tot_r;

  assign stripped = cfg_r.input_flags[IF_ISTRIP] ? {1'b0, in_byte_r[6:0]} : in_byte_r;
  always_comb begin
    mapped = stripped;
    if (cfg_r.input_flags[IF_ICRNL] && (stripped == ASCII_CR)) begin
      mapped = ASCII_NL;
    end else if (cfg_r.input_flags[IF_INLCR] && (stripped == ASCII_NL)) begin
      mapped = ASCII_CR;
    end
  end

  assign cmp_a = (state_r == S_SIG) ? in_byte_r : mapped;

  tild_cmp u_cmp (
    .cfg    (cfg_r),
    .sel    (sel_r),
    .a_byte (cmp_a),
    .eq     (cmp_eq)
  );

  assign count_dm1 = count_r - CW'(1);
  assign count_p1  = count_r + CW'(1);
  assign line_end  = eol_hit_r || (mapped == ASCII_NL);

  // decode of the item class into an echo plan, a flush length, line buffer access and the new line count
  always_comb begin
    dec_valid  = 1'b0;
    dec_rd     = 1'b0;
    dec_wr     = 1'b0;
    dec_rm     = rm_r;
    dec_e_kind = EK_SINGLE;
    dec_e_len  = 3'd0;
    dec_e_byte = mapped;
    dec_e_dest = 1'b1;
    dec_f_len  = '0;
    dec_count  = count_r;
    rd_addr    = f_idx_r[AW-1:0];
    if (state_r == S_DEC) begin
      dec_valid = 1'b1;
      if (!cfg_r.local_flags[LF_ICANON]) begin
        dec_e_len  = 3'd1;
        dec_e_dest = 1'b0;
      end else if (erase_hit_r) begin
        dec_rm = (count_r != '0);
        if (count_r != '0) begin
          dec_rd    = 1'b1;
          rd_addr   = count_dm1[AW-1:0];
          dec_count = count_dm1;
        end
      end else if (eof_hit_r) begin
        if (count_r != '0) begin
          dec_f_len = count_r;
          dec_count = '0;
        end else begin
          dec_e_len  = 3'd1;
          dec_e_dest = 1'b0;
          dec_e_byte = ASCII_NUL;
        end
      end else if (count_r < DEPTH_C) begin
        dec_wr = 1'b1;
        if (cfg_r.local_flags[LF_ECHO]) begin
          if (is_ctrl(mapped) && (mapped != ASCII_NL)) begin
            dec_e_byte = caret_letter(mapped);
            if (line_end && (count_p1 == DEPTH_C)) begin
              dec_e_len = 3'd1;
            end else begin
              dec_e_kind = EK_PAIR;
              dec_e_len  = 3'd2;
            end
          end else begin
            dec_e_len = 3'd1;
          end
        end else if (line_end && cfg_r.local_flags[LF_ECHONL]) begin
          dec_e_len = 3'd1;
        end
        if (line_end) begin
          dec_f_len = count_p1;
          dec_count = '0;
        end else begin
          dec_count = count_p1;
        end
      end
    end else if (state_r == S_ERD) begin
      dec_valid = 1'b1;
      if (cfg_r.local_flags[LF_ECHO] && cfg_r.local_flags[LF_ECHOE]) begin
        dec_e_kind = EK_BS;
        if (rm_r) begin
          dec_e_len = is_ctrl(rd_data_r) ? 3'd6 : 3'd3;
        end
      end else if (cfg_r.local_flags[LF_ECHO]) begin
        dec_e_kind = EK_PAIR;
        dec_e_len  = 3'd2;
        dec_e_byte = caret_letter(mapped);
      end
    end
  end

  assign dec_sum = RW'(dec_e_len) + RW'(dec_f_len);
  assign dec_tot = (dec_sum > MAX_RES) ? MAX_RES : dec_sum;

  always_comb begin
    unique case (e_kind_r)
      EK_SINGLE: begin
        echo_byte = e_byte_r;
        echo_dest = e_dest_r;
      end
      EK_PAIR: begin
        echo_byte = (e_idx_r == 3'd0) ? ASCII_CARET : e_byte_r;
        echo_dest = 1'b1;
      end
      EK_BS: begin
        echo_byte = ((e_idx_r == 3'd1) || (e_idx_r == 3'd4)) ? ASCII_SP : ASCII_BS;
        echo_dest = 1'b1;
      end
      default: begin
        echo_byte = e_byte_r;
        echo_dest = e_dest_r;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SIG;
        end
      end
      S_SIG: begin
        if (sel_r == CMP_SUSP) begin
          state_nxt = (cfg_r.local_flags[LF_ISIG] && (sig_hit_r || cmp_eq)) ? S_IDLE : S_CLS;
        end
      end
      S_CLS: begin
        if (sel_r == CMP_EOL) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC, S_ERD: begin
        if ((state_r == S_DEC) && dec_rd) begin
          state_nxt = S_ERD;
        end else if ((state_r == S_DEC) && cfg_r.local_flags[LF_ICANON] && erase_hit_r) begin
          state_nxt = S_ERD;
        end else if (dec_tot == '0) begin
          state_nxt = S_IDLE;
        end else if (dec_e_len != 3'd0) begin
          state_nxt = S_ECHO;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          if (last_item) begin
            state_nxt = S_IDLE;
          end else if ((e_idx_r + 3'd1) == e_len_r) begin
            state_nxt = S_FRD;
          end
        end
      end
      S_FRD: begin
        state_nxt = S_FOUT;
      end
      S_FOUT: begin
        if (slot_free) begin
          state_nxt = last_item ? S_IDLE : S_FRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ch.ready   = (state_r == S_IDLE);
    sel_nxt       = sel_r;
    sig_hit_nxt   = sig_hit_r;
    erase_hit_nxt = erase_hit_r;
    eof_hit_nxt   = eof_hit_r;
    eol_hit_nxt   = eol_hit_r;
    rm_nxt        = rm_r;
    count_nxt     = count_r;
    f_len_nxt     = f_len_r;
    f_idx_nxt     = f_idx_r;
    e_kind_nxt    = e_kind_r;
    e_len_nxt     = e_len_r;
    e_idx_nxt     = e_idx_r;
    e_byte_nxt    = e_byte_r;
    e_dest_nxt    = e_dest_r;
    tot_nxt       = tot_r;
    idx_nxt       = idx_r;
    load          = 1'b0;
    out_dest_nxt  = out_dest_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (accept) begin
      sel_nxt     = CMP_INTR;
      sig_hit_nxt = 1'b0;
    end

    unique case (state_r)
      S_SIG: begin
        sig_hit_nxt = sig_hit_r || cmp_eq;
        unique case (sel_r)
          CMP_INTR: sel_nxt = CMP_QUIT;
          CMP_QUIT: sel_nxt = CMP_SUSP;
          default:  sel_nxt = CMP_ERASE;
        endcase
      end
      S_CLS: begin
        unique case (sel_r)
          CMP_ERASE: begin
            erase_hit_nxt = cmp_eq;
            sel_nxt       = CMP_EOF;
          end
          CMP_EOF: begin
            eof_hit_nxt = cmp_eq;
            sel_nxt     = CMP_EOL;
          end
          default: begin
            eol_hit_nxt = cmp_eq;
          end
        endcase
      end
      S_ECHO: begin
        if (slot_free) begin
          load         = 1'b1;
          out_dest_nxt = echo_dest;
          out_byte_nxt = echo_byte;
          out_last_nxt = last_item;
          idx_nxt      = idx_r + RW'(1);
          e_idx_nxt    = e_idx_r + 3'd1;
        end
      end
      S_FOUT: begin
        if (slot_free) begin
          load         = 1'b1;
          out_dest_nxt = 1'b0;
          out_byte_nxt = rd_data_r;
          out_last_nxt = last_item;
          idx_nxt      = idx_r + RW'(1);
          f_idx_nxt    = f_idx_r + CW'(1);
        end
      end
      default: begin
      end
    endcase

    if (dec_valid) begin
      rm_nxt     = dec_rm;
      count_nxt  = dec_count;
      f_len_nxt  = dec_f_len;
      f_idx_nxt  = '0;
      e_kind_nxt = dec_e_kind;
      e_len_nxt  = dec_e_len;
      e_idx_nxt  = 3'd0;
      e_byte_nxt = dec_e_byte;
      e_dest_nxt = dec_e_dest;
      tot_nxt    = dec_tot;
      idx_nxt    = '0;
    end

    out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.dest     = out_dest_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  always_ff @(posedge clk) begin
    if (dec_wr) begin
      line_mem[count_r[AW-1:0]] <= mapped;
    end
    if (dec_rd || (state_r == S_FRD)) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      cfg_r.input_flags <= 3'd2;
      cfg_r.local_flags <= 5'd15;
      cfg_r.intr_char   <= 8'd3;
      cfg_r.quit_char   <= 8'd28;
      cfg_r.susp_char   <= 8'd26;
      cfg_r.erase_char  <= 8'd127;
      cfg_r.eof_char    <= 8'd4;
      cfg_r.eol_char    <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_INPUT_FLAGS: cfg_r.input_flags <= cfg_wdata[2:0];
          CFG_LOCAL_FLAGS: cfg_r.local_flags <= cfg_wdata[4:0];
          CFG_INTR_CHAR:   cfg_r.intr_char   <= cfg_wdata;
          CFG_QUIT_CHAR:   cfg_r.quit_char   <= cfg_wdata;
          CFG_SUSP_CHAR:   cfg_r.susp_char   <= cfg_wdata;
          CFG_ERASE_CHAR:  cfg_r.erase_char  <= cfg_wdata;
          CFG_EOF_CHAR:    cfg_r.eof_char    <= cfg_wdata;
          CFG_EOL_CHAR:    cfg_r.eol_char    <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_ch.in_byte;
    end
    sel_r       <= sel_nxt;
    sig_hit_r   <= sig_hit_nxt;
    erase_hit_r <= erase_hit_nxt;
    eof_hit_r   <= eof_hit_nxt;
    eol_hit_r   <= eol_hit_nxt;
    rm_r        <= rm_nxt;
    f_len_r     <= f_len_nxt;
    f_idx_r     <= f_idx_nxt;
    e_kind_r    <= e_kind_nxt;
    e_len_r     <= e_len_nxt;
    e_idx_r     <= e_idx_nxt;
    e_byte_r    <= e_byte_nxt;
    e_dest_r    <= e_dest_nxt;
    tot_r       <= tot_nxt;
    idx_r       <= idx_nxt;
    out_dest_r  <= out_dest_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("line count beyond buffer depth");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_last_nxt) |=> (state_r == S_IDLE))
    else $error("sequencer busy after final result");

  a_echo_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ECHO) |-> (e_idx_r < e_len_r))
    else $error("echo index past echo length");

  a_flush_index: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FRD) || (state_r == S_FOUT)) |-> (f_idx_r < f_len_r))
    else $error("flush index past line length");

  a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ECHO) || (state_r == S_FOUT)) |-> (idx_r < tot_r && tot_r <= MAX_RES))
    else $error("result count out of range");

endmodule

>>> src/tild_cmp.sv
module tild_cmp
  import tild_pkg::*;
(
  input  tild_cfg_t  cfg,
  input  cmp_sel_t   sel,
  input  logic [7:0] a_byte,
  output logic       eq
);

  logic [7:0] target;

  always_comb begin
    unique case (sel)
      CMP_INTR:  target = cfg.intr_char;
      CMP_QUIT:  target = cfg.quit_char;
      CMP_SUSP:  target = cfg.susp_char;
      CMP_ERASE: target = cfg.erase_char;
      CMP_EOF:   target = cfg.eof_char;
      CMP_EOL:   target = cfg.eol_char;
      default:   target = cfg.intr_char;
    endcase
  end

  assign eq = (a_byte == target) && ((sel != CMP_EOL) || (target != ASCII_NUL));

endmodule

>>> sim/tb_top.sv
module tb_top;
  import tild_pkg::*;

  localparam int LINE_DEPTH    = 32;
  localparam int MAX_HITS      = LINE_DEPTH + 1;
  localparam int TOTAL_KEYS    = 430;
  localparam int PHASE_KEYS    = 50;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 3000;

  typedef struct {
    bit       dest;
    bit [7:0] data;
    bit       last;
  } byte_out_t;

  class line_disc_board;
    tild_cfg_t   setup;
    bit [7:0]    line_store [LINE_DEPTH];
    int unsigned line_len;
    byte_out_t   key_out [$];
    byte_out_t   due [$];
    int          errors;
    int          n_keys;
    int          n_reader;
    int          n_echo;

    function new();
      setup = '{3'd2, 5'd15, 8'd3, 8'd28, 8'd26, ASCII_DEL, 8'd4, ASCII_NUL};
      line_len = 0;
      errors = 0;
      n_keys = 0;
      n_reader = 0;
      n_echo = 0;
    endfunction

    function int due_count();
      return due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [7:0] v);
      case (idx)
        CFG_INPUT_FLAGS: setup.input_flags = v[2:0];
        CFG_LOCAL_FLAGS: setup.local_flags = v[4:0];
        CFG_INTR_CHAR:   setup.intr_char = v;
        CFG_QUIT_CHAR:   setup.quit_char = v;
        CFG_SUSP_CHAR:   setup.susp_char = v;
        CFG_ERASE_CHAR:  setup.erase_char = v;
        CFG_EOF_CHAR:    setup.eof_char = v;
        default:         setup.eol_char = v;
      endcase
    endfunction

    function bit is_ctrl(bit [7:0] b);
      return (b < ASCII_SP) || (b == ASCII_DEL);
    endfunction

    function bit [7:0] caret_of(bit [7:0] b);
      bit [7:0] t;
      t = ASCII_AT + b;
      return {1'b0, t[6:0]};
    endfunction

    function void put_out(bit d, bit [7:0] b);
      byte_out_t r;
      if (key_out.size() >= MAX_HITS) return;
      r.dest = d;
      r.data = b;
      r.last = 1'b0;
      key_out.push_back(r);
    endfunction

    function void rub_out();
      put_out(1'b1, ASCII_BS);
      put_out(1'b1, ASCII_SP);
      put_out(1'b1, ASCII_BS);
    endfunction

    function void flush_line();
      for (int i = 0; i < line_len; i++) put_out(1'b0, line_store[i]);
      line_len = 0;
    endfunction

    function void take_keystroke(bit [7:0] raw);
      bit [7:0]  ch;
      bit        echo_on;
      bit        echoe_on;
      bit        echonl_on;
      bit        line_end;
      bit        was_ctrl;
      byte_out_t r;
      ch = raw;
      echo_on = setup.local_flags[LF_ECHO];
      echoe_on = setup.local_flags[LF_ECHOE];
      echonl_on = setup.local_flags[LF_ECHONL];
      key_out.delete();
      n_keys++;
      if (setup.local_flags[LF_ISIG] &&
          (ch == setup.intr_char || ch == setup.quit_char || ch == setup.susp_char)) return;
      if (setup.input_flags[IF_ISTRIP]) ch[7] = 1'b0;
      if (setup.input_flags[IF_ICRNL] && ch == ASCII_CR) ch = ASCII_NL;
      else if (setup.input_flags[IF_INLCR] && ch == ASCII_NL) ch = ASCII_CR;
      if (!setup.local_flags[LF_ICANON]) begin
        put_out(1'b0, ch);
      end else if (ch == setup.erase_char) begin
        if (line_len > 0) begin
          line_len--;
          was_ctrl = is_ctrl(line_store[line_len]);
          if (echo_on && echoe_on) begin
            rub_out();
            if (was_ctrl) rub_out();
          end
        end
        if (echo_on && !echoe_on) begin
          put_out(1'b1, ASCII_CARET);
          put_out(1'b1, caret_of(ch));
        end
      end else if (ch == setup.eof_char) begin
        if (line_len > 0) flush_line();
        else put_out(1'b0, ASCII_NUL);
      end else if (line_len < LINE_DEPTH) begin
        line_end = (setup.eol_char != ASCII_NUL && ch == setup.eol_char) || ch == ASCII_NL;
        line_store[line_len] = ch;
        line_len++;
        if (echo_on) begin
          if (is_ctrl(ch) && ch != ASCII_NL) begin
            if (!(line_end && line_len + 2 > MAX_HITS)) put_out(1'b1, ASCII_CARET);
            put_out(1'b1, caret_of(ch));
          end else begin
            put_out(1'b1, ch);
          end
        end
        if (line_end) begin
          if (!echo_on && echonl_on) put_out(1'b1, ch);
          flush_line();
        end
      end
      for (int i = 0; i < key_out.size(); i++) begin
        r = key_out[i];
        r.last = (i == key_out.size() - 1);
        due.push_back(r);
      end
    endfunction

    function void flag(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    function void match_delivery(bit d, bit [7:0] b, bit l);
      byte_out_t e;
      if (d) n_echo++;
      else n_reader++;
      if (due.size() == 0) begin
        flag($sformatf("unexpected item: dest %0d byte %02h last %0d", d, b, l));
        return;
      end
      e = due.pop_front();
      if (e.dest != d) flag($sformatf("dest: expected %0d, got %0d", e.dest, d));
      if (e.data != b) flag($sformatf("out_byte: expected %02h, got %02h", e.data, b));
      if (e.last != l) flag($sformatf("last: expected %0d, got %0d", e.last, l));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tild_in_if  in_if();
  tild_out_if out_if();

  termios_input_line_discipline_core #(.LINE_DEPTH(LINE_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  line_disc_board board;
  int keys_sent     = 0;
  int burst_left    = 0;
  int setups_loaded = 0;
  int hold_asked    = 0;
  int idle_cycles   = 0;

  wire in_take  = in_if.valid && in_if.ready;
  wire out_take = out_if.valid && out_if.ready;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_take) board.take_keystroke(in_if.in_byte);
    if (rst_n && out_take) board.match_delivery(out_if.dest, out_if.out_byte, out_if.last);
  end

  always @(posedge clk) begin
    if (!rst_n || in_take || out_take) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d items still due",
               $time, idle_cycles, board.due_count());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int mode;
    int left;
    int hold;
    int hold_given;
    mode = 0;
    left = 0;
    hold = 0;
    hold_given = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_given) begin
        hold_given++;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ~out_if.ready;
        endcase
      end
    end
  end

  task automatic push_key(input bit [7:0] b);
    int gap;
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    keys_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (board.due_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input bit [7:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  task automatic load_setup(input tild_cfg_t s);
    bit [7:0] junk;
    junk = 8'($urandom);
    put_reg(CFG_INPUT_FLAGS, {junk[7:3], s.input_flags});
    put_reg(CFG_LOCAL_FLAGS, {junk[2:0], s.local_flags});
    put_reg(CFG_INTR_CHAR, s.intr_char);
    put_reg(CFG_QUIT_CHAR, s.quit_char);
    put_reg(CFG_SUSP_CHAR, s.susp_char);
    put_reg(CFG_ERASE_CHAR, s.erase_char);
    put_reg(CFG_EOF_CHAR, s.eof_char);
    put_reg(CFG_EOL_CHAR, s.eol_char);
    cfg_we <= 1'b0;
    @(posedge clk);
    setups_loaded++;
  endtask

  function automatic tild_cfg_t mk_setup(bit [2:0] ifl, bit [4:0] lfl, bit [7:0] erase,
                                         bit [7:0] eol);
    return '{ifl, lfl, 8'd3, 8'd28, 8'd26, erase, 8'd4, eol};
  endfunction

  function automatic bit [7:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      3:       return ASCII_DEL;
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  function automatic tild_cfg_t roll_setup();
    tild_cfg_t s;
    s.input_flags = 3'($urandom_range(0, 7));
    s.local_flags = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 4) != 0) s.local_flags[LF_ICANON] = 1'b1;
    s.intr_char = pick_char();
    s.quit_char = pick_char();
    s.susp_char = pick_char();
    s.erase_char = pick_char();
    s.eof_char = pick_char();
    s.eol_char = ($urandom_range(0, 2) == 0) ? ASCII_NUL : pick_char();
    return s;
  endfunction

  task automatic type_run(input tild_cfg_t s);
    int       kind;
    int       len;
    bit [7:0] k;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      if ($urandom_range(0, 4) == 0)
        len = $urandom_range(0, 1) ? $urandom_range(31, 32) : $urandom_range(28, 36);
      else
        len = $urandom_range(0, 12);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1:    k = 8'($urandom_range(0, 255));
          2:       k = s.erase_char;
          default: k = 8'($urandom_range(ASCII_SP, ASCII_DEL - 1));
        endcase
        push_key(k);
      end
      case ($urandom_range(0, 4))
        0:       k = ASCII_NL;
        1:       k = ASCII_CR;
        2:       k = s.eol_char;
        3:       k = s.eof_char;
        default: k = 8'($urandom_range(0, 255));
      endcase
      push_key(k);
    end else if (kind < 8) begin
      repeat ($urandom_range(1, 8)) push_key(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      case ($urandom_range(0, 7))
        0:       k = s.intr_char;
        1:       k = s.quit_char;
        2:       k = s.susp_char;
        3:       k = s.erase_char;
        4:       k = s.eof_char;
        5:       k = s.eol_char;
        6:       k = ASCII_NL;
        default: k = ASCII_CR;
      endcase
      push_key(k);
    end else begin
      repeat ($urandom_range(1, 6)) push_key(s.erase_char);
    end
  endtask

  initial begin
    bit [7:0]  warm_keys [15];
    bit [7:0]  strip_keys [4];
    bit [7:0]  raw_keys [3];
    bit [7:0]  caret_keys [5];
    tild_cfg_t s;
    int        quota;
    warm_keys = '{8'h03, 8'h1C, 8'h1A, 8'h61, 8'h01, ASCII_DEL, ASCII_DEL,
                  ASCII_DEL, 8'hFF, ASCII_CR, 8'h04, 8'h78, 8'h04, ASCII_NUL,
                  ASCII_NL};
    strip_keys = '{8'h68, 8'h8A, 8'hFF, 8'h83};
    raw_keys = '{8'h03, 8'h80, ASCII_NUL};
    caret_keys = '{8'h71, ASCII_BS, ASCII_BS, ASCII_BS, ASCII_NL};
    board = new();
    in_if.valid <= 1'b0;
    in_if.in_byte <= ASCII_NUL;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_INPUT_FLAGS;
    cfg_wdata <= ASCII_NUL;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (warm_keys[i]) push_key(warm_keys[i]);

    settle();
    load_setup(mk_setup(3'((1 << IF_ISTRIP) | (1 << IF_INLCR)),
                        5'((1 << LF_ICANON) | (1 << LF_ECHONL)), ASCII_DEL, ASCII_CR));
    foreach (strip_keys[i]) push_key(strip_keys[i]);

    settle();
    load_setup(mk_setup(3'd0, 5'd0, ASCII_DEL, ASCII_NUL));
    foreach (raw_keys[i]) push_key(raw_keys[i]);

    settle();
    load_setup(mk_setup(3'd0, 5'((1 << LF_ISIG) | (1 << LF_ICANON) | (1 << LF_ECHO)),
                        ASCII_BS, ASCII_NUL));
    foreach (caret_keys[i]) push_key(caret_keys[i]);

    for (int p = 0; keys_sent < TOTAL_KEYS; p++) begin
      case (p)
        0:       s = '0;
        1:       s = '1;
        default: s = roll_setup();
      endcase
      settle();
      load_setup(s);
      quota = keys_sent + PHASE_KEYS;
      if (p == 2) begin
        type_run(s);
        hold_asked++;
      end
      while (keys_sent < quota) type_run(s);
    end

    settle();
    $display("Sent %0d input items over %0d register setups;",
             board.n_keys, setups_loaded);
    $display("checked %0d reader and %0d echo items.", board.n_reader, board.n_echo);
    if (board.errors == 0 && board.due_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
